[design/rsbe_pkg.sv]
// ----------------------------------------------------------------------------
// rsbe_pkg
// Shared types, constants and helper functions for the record sorter with
// balanced emission.
// ----------------------------------------------------------------------------
package rsbe_pkg;

  localparam int LC_W            = 6;   // load count / entry index width
  localparam int QTY_W           = 16;
  localparam int DAY_W           = 4;
  localparam int SHF_W           = 3;
  localparam int CFG_W           = 4;   // widest configuration register
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int RESULT_LIMIT    = 32;
  localparam int STK_D           = 8;   // range stack depth of the emitter

  localparam logic [DAY_W-1:0] DAYS_RST   = 4'd7;
  localparam logic [SHF_W-1:0] SHIFTS_RST = 3'd4;

  // configuration register indexes
  localparam logic CFG_NUM_DAYS   = 1'b0;
  localparam logic CFG_NUM_SHIFTS = 1'b1;

  typedef struct packed {
    logic [QTY_W-1:0] qty;
    logic [DAY_W-1:0] day;
    logic [SHF_W-1:0] shift;
  } data_t;

  // load index breaks ties so that equal keys keep load order
  typedef struct packed {
    data_t           d;
    logic [LC_W-1:0] idx;
  } rec_t;

  typedef struct packed {
    logic shift;   // move every held record one cell toward cell 0
    logic flush;   // drop a partial set; cell 0 may take a new record
  } cell_ctrl_t;

  typedef struct packed {
    logic            start;
    logic [LC_W-1:0] total;
  } emit_req_t;

  function automatic logic key_greater(rec_t a, rec_t b);
    return {a.d.qty, a.d.day, a.d.shift, a.idx} > {b.d.qty, b.d.day, b.d.shift, b.idx};
  endfunction

  function automatic logic [SHF_W-1:0] sat_shifts(logic [SHF_W-1:0] ns);
    logic [SHF_W-1:0] s;
    s = ns;
    if (ns == 3'd0) s = 3'd1;
    else if (ns > 3'd4) s = 3'd4;
    return s;
  endfunction

  function automatic logic [LC_W-1:0] set_size(logic [DAY_W-1:0] nd,
                                                logic [SHF_W-1:0] ns,
                                                logic [LC_W-1:0]  cap);
    logic [DAY_W-1:0] d;
    logic [LC_W-1:0]  n;
    d = nd;
    if (nd == 4'd0) d = 4'd1;
    else if (nd > 4'd8) d = 4'd8;
    n = LC_W'(d) * LC_W'(sat_shifts(ns));
    if (n > cap) n = cap;
    return n;
  endfunction

  // idx / s for idx < 32 and s in 1..4; divide by 3 via 11/32
  function automatic logic [4:0] idx_quot(logic [4:0] idx, logic [SHF_W-1:0] s);
    logic [8:0] prod;
    logic [4:0] q;
    prod = {4'b0000, idx} * 9'd11;
    case (s)
      3'd1:    q = idx;
      3'd2:    q = idx >> 1;
      3'd4:    q = idx >> 2;
      default: q = {1'b0, prod[8:5]};
    endcase
    return q;
  endfunction

endpackage

[design/rsbe_ram.sv]
// ----------------------------------------------------------------------------
// rsbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rsbe_cell.sv]
// ----------------------------------------------------------------------------
// rsbe_cell
// One insertion-sort cell: keeps the smaller of its record and the incoming
// one, passes the larger to the right neighbor on the next cycle.
// ----------------------------------------------------------------------------
module rsbe_cell
  import rsbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       in_valid,
  input  rec_t       in_rec,
  input  logic       nb_valid,
  input  rec_t       nb_rec,
  output logic       held_valid,
  output rec_t       held_rec,
  output logic       pass_valid,
  output rec_t       pass_rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= nb_valid;
      held_rec   <= nb_rec;
      pass_valid <= 1'b0;
    end else if (ctrl.flush) begin
      held_valid <= in_valid;
      held_rec   <= in_rec;
      pass_valid <= 1'b0;
    end else if (in_valid) begin
      if (!held_valid) begin
        held_valid <= 1'b1;
        held_rec   <= in_rec;
        pass_valid <= 1'b0;
      end else if (key_greater(held_rec, in_rec)) begin
        held_rec   <= in_rec;
        pass_valid <= 1'b1;
        pass_rec   <= held_rec;
      end else begin
        pass_valid <= 1'b1;
        pass_rec   <= in_rec;
      end
    end else begin
      pass_valid <= 1'b0;
    end
  end

endmodule

[design/rsbe_emit.sv]
// ----------------------------------------------------------------------------
// rsbe_emit
// Walks the sorted set in balanced tree order (midpoint, left half, right
// half) with a small range stack and drives the result channel.
// ----------------------------------------------------------------------------
module rsbe_emit
  import rsbe_pkg::*;
#(
  parameter int AW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  emit_req_t         req,
  input  data_t             rd_data,
  output logic [AW-1:0]     rd_addr,
  output logic              busy,
  input  logic              result_stall,
  output logic              result_valid,
  output logic [QTY_W-1:0]  out_quantity,
  output logic [DAY_W-1:0]  out_day,
  output logic [SHF_W-1:0]  out_shift,
  output logic              is_last
);

  localparam int SP_W = $clog2(STK_D);

  typedef enum logic [1:0] {E_IDLE, E_POP, E_DATA, E_HOLD} estate_t;

  estate_t           state;
  logic [LC_W-1:0]   stk_lo [STK_D];
  logic [LC_W-1:0]   stk_hi [STK_D];
  logic [SP_W:0]     sp;
  logic [LC_W-1:0]   total;
  logic [LC_W-1:0]   emit_cnt;
  logic              last_pend;

  logic [SP_W-1:0]   top;
  logic [SP_W-1:0]   top_up;
  logic [LC_W-1:0]   lo, hi, mid;
  logic [LC_W:0]     sum;
  logic              push_r, push_l;

  assign top    = SP_W'(sp - 1'b1);
  assign top_up = top + SP_W'(push_r);
  assign lo     = stk_lo[top];
  assign hi     = stk_hi[top];
  assign sum    = {1'b0, lo} + {1'b0, hi};
  assign mid    = sum[LC_W:1];
  assign push_r = mid < hi;
  assign push_l = mid > lo;
  assign busy   = (state != E_IDLE) || req.start;

  // address is presented during E_POP so the registered read is ready in E_DATA
  assign rd_addr = mid[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= E_IDLE;
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          if (req.start) begin
            stk_lo[0] <= '0;
            stk_hi[0] <= req.total - 1'b1;
            sp        <= (SP_W+1)'(1);
            total     <= req.total;
            emit_cnt  <= '0;
            state     <= E_POP;
          end
        end
        E_POP: begin
          last_pend <= (emit_cnt == total - 1'b1);
          // right half goes below left half so the left one pops first
          if (push_r) begin
            stk_lo[top] <= mid + 1'b1;
            stk_hi[top] <= hi;
          end
          if (push_l) begin
            stk_lo[top_up] <= lo;
            stk_hi[top_up] <= mid - 1'b1;
          end
          sp    <= sp - 1'b1 + (SP_W+1)'(push_r) + (SP_W+1)'(push_l);
          state <= E_DATA;
        end
        E_DATA: begin
          out_quantity <= rd_data.qty;
          out_day      <= rd_data.day;
          out_shift    <= rd_data.shift;
          is_last      <= last_pend;
          result_valid <= 1'b1;
          state        <= E_HOLD;
        end
        E_HOLD: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            emit_cnt     <= emit_cnt + 1'b1;
            state        <= is_last ? E_IDLE : E_POP;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

[design/record_sorter_balanced_emit_unit.sv]
// ----------------------------------------------------------------------------
// record_sorter_balanced_emit_unit
// Collects quantities into a set, sorts by (quantity, day, shift) and emits
// the set in balanced tree order.
// ----------------------------------------------------------------------------
// Item channel (item_valid/item_stall, quantity): one transaction per cycle
// while a set is loading. Each item is tagged with day and shift from its
// position in the set and enters a row of sort cells, where it ripples to its
// rank one cell per cycle.
// Once num_days * num_shifts items (capped at the cell count) are in, the
// unit stalls the item channel while the last record settles in the row
// and while the row is shifted into the result RAM. A previous set still
// being emitted delays this step.
// Result channel (result_valid/result_stall): each result goes through a range
// stack pop and RAM read, an output register load and a handoff, so a set of
// n items yields n results once the RAM is filled; the next set loads
// meanwhile. is_last marks the final result of a set.
// Under result_stall the output register holds and emission pauses.
// Configuration (cfg_write, cfg_index, cfg_data) is taken at once.
// Reset clears the cells, counters and emitter and sets num_days to 7 and
// num_shifts to 4; RAM contents are only read after being written.
// ----------------------------------------------------------------------------
module record_sorter_balanced_emit_unit
  import rsbe_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [QTY_W-1:0] quantity,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [QTY_W-1:0] out_quantity,
  output logic [DAY_W-1:0] out_day,
  output logic [SHF_W-1:0] out_shift,
  output logic             is_last,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CELLS = (MAX_ENTRIES < RESULT_LIMIT) ? MAX_ENTRIES : RESULT_LIMIT;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [1:0] {S_LOAD, S_DRAIN, S_UNLOAD} state_t;

  state_t           state;
  logic [DAY_W-1:0] num_days;
  logic [SHF_W-1:0] num_shifts;
  logic [LC_W-1:0]  load_count;
  logic [LC_W-1:0]  cnt;
  logic [LC_W-1:0]  total;
  emit_req_t        req;

  logic [LC_W-1:0]  n;
  logic [SHF_W-1:0] s;
  logic             item_accept;
  logic             restart;
  logic [LC_W-1:0]  idx;
  logic [LC_W-1:0]  load_next;
  logic [4:0]       quot;
  logic [2:0]       qs;
  logic [2:0]       rem;
  logic [LC_W-1:0]  day_full;
  rec_t             new_rec;
  cell_ctrl_t       ctrl;
  logic             emit_busy;
  data_t            rd_data;
  logic [AW-1:0]    rd_addr;

  logic hv [CELLS];
  rec_t hr [CELLS];
  logic pv [CELLS];
  rec_t pr [CELLS];

  assign n           = set_size(num_days, num_shifts, LC_W'(CELLS));
  assign s           = sat_shifts(num_shifts);
  assign item_stall  = (state != S_LOAD);
  assign item_accept = item_valid && !item_stall;
  assign restart     = (load_count >= n);
  assign idx         = restart ? '0 : load_count;
  assign load_next   = idx + 1'b1;

  // day and shift from the position in the set
  assign quot     = idx_quot(idx[4:0], s);
  assign qs       = 3'(quot * s);
  assign rem      = idx[2:0] - qs;
  assign day_full = {1'b0, quot} + 6'd1;

  assign new_rec.d.qty   = quantity;
  assign new_rec.d.day   = day_full[DAY_W-1:0];
  assign new_rec.d.shift = rem + 3'd1;
  assign new_rec.idx     = idx;

  // a partial set that a register change leaves at or above the set size is dropped
  assign ctrl.shift = (state == S_UNLOAD);
  assign ctrl.flush = item_accept && restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      num_days   <= DAYS_RST;
      num_shifts <= SHIFTS_RST;
      load_count <= '0;
      cnt        <= '0;
      total      <= '0;
      req        <= '0;
    end else begin
      req.start <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CFG_NUM_DAYS:   num_days   <= cfg_data[DAY_W-1:0];
          CFG_NUM_SHIFTS: num_shifts <= cfg_data[SHF_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (item_accept) begin
            if (load_next >= n) begin
              load_count <= '0;
              total      <= load_next;
              cnt        <= '0;
              state      <= S_DRAIN;
            end else begin
              load_count <= load_next;
            end
          end
        end
        S_DRAIN: begin
          if (cnt < total) begin
            cnt <= cnt + 1'b1;
          end else if (!emit_busy) begin
            cnt   <= '0;
            state <= S_UNLOAD;
          end
        end
        S_UNLOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt == total - 1'b1) begin
            req.start <= 1'b1;
            req.total <= total;
            state     <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic in_v;
    rec_t in_r;
    logic nb_v;
    rec_t nb_r;

    if (i == 0) begin : g_head
      assign in_v = item_accept;
      assign in_r = new_rec;
    end else begin : g_body
      assign in_v = pv[i-1] && !ctrl.flush;
      assign in_r = pr[i-1];
    end

    if (i == CELLS - 1) begin : g_tail
      assign nb_v = 1'b0;
      assign nb_r = hr[i];
    end else begin : g_inner
      assign nb_v = hv[i+1];
      assign nb_r = hr[i+1];
    end

    rsbe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_valid   (in_v),
      .in_rec     (in_r),
      .nb_valid   (nb_v),
      .nb_rec     (nb_r),
      .held_valid (hv[i]),
      .held_rec   (hr[i]),
      .pass_valid (pv[i]),
      .pass_rec   (pr[i])
    );
  end

  rsbe_ram #(
    .WIDTH ($bits(data_t)),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.shift && hv[0]),
    .waddr (cnt[AW-1:0]),
    .wdata (hr[0].d),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rsbe_emit #(
    .AW (AW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rd_data      (rd_data),
    .rd_addr      (rd_addr),
    .busy         (emit_busy),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .out_quantity (out_quantity),
    .out_day      (out_day),
    .out_shift    (out_shift),
    .is_last      (is_last)
  );

endmodule

[design/rsbe_chk.sv]
// ----------------------------------------------------------------------------
// rsbe_chk
// Port-level checks for the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
module rsbe_chk
  import rsbe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input logic [QTY_W-1:0] out_quantity,
  input logic [DAY_W-1:0] out_day,
  input logic [SHF_W-1:0] out_shift,
  input logic             is_last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result_valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(out_quantity) && $stable(out_day) && $stable(out_shift) && $stable(is_last))
    else $error("result payload changed while stalled");

  // every emitted entry carries a tag from a legal day and shift
  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> out_day >= 4'd1 && out_day <= 4'd8 &&
                     out_shift >= 3'd1 && out_shift <= 3'd4)
    else $error("day or shift tag out of range");

  // the emitter needs a RAM read between two results
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("back-to-back results from the emitter");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set right after reset");

endmodule

bind record_sorter_balanced_emit_unit rsbe_chk u_rsbe_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_quantity (out_quantity),
  .out_day      (out_day),
  .out_shift    (out_shift),
  .is_last      (is_last)
);

[dv/tb_record_sorter_balanced_emit_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_record_sorter_balanced_emit_unit
// Loads quantity sets under many day/shift settings. Each finished set is
// sorted and walked in balanced-tree order by a local model, and every result
// transaction is compared field by field with it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_record_sorter_balanced_emit_unit;
  import rsbe_pkg::*;

  localparam int RAND_ITEMS  = 335;
  localparam int TAIL_START  = 280;   // no idling from here on
  localparam int PAUSE       = 200;   // longer than sort plus emission of a full set
  localparam int STALL_LIMIT = 5000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] days_w;
    logic [CFG_W-1:0] shifts_w;
    logic [QTY_W-1:0] qty;
    logic             typed;   // single-entry set: result is (qty, 1, 1, last)
  } stim_row_t;

  typedef struct packed {
    data_t d;
    logic  last;
  } emit_t;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  logic [QTY_W-1:0] quantity;
  logic             result_valid;
  logic             result_stall;
  logic [QTY_W-1:0] out_quantity;
  logic [DAY_W-1:0] out_day;
  logic [SHF_W-1:0] out_shift;
  logic             is_last;
  logic             cfg_write;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  record_sorter_balanced_emit_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .quantity     (quantity),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_quantity (out_quantity),
    .out_day      (out_day),
    .out_shift    (out_shift),
    .is_last      (is_last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // model state
  logic [DAY_W-1:0] days_reg;
  logic [SHF_W-1:0] shifts_reg;
  data_t            stock [MAX_ENTRIES_DEF];
  int               load_cnt;
  emit_t            due [$];     // results still owed by the block, oldest first
  emit_t            fresh [$];   // results caused by the latest item

  stim_row_t dir_rows [$];
  int        mismatches;
  int        items_in;
  int        results_out;
  int        sets_done;
  int        cfg_writes;
  int        idle_cycles;
  int        gap_odds;
  bit        tail_quiet;
  bit        moved;
  emit_t     head;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int cur_set_size();
    int d;
    int s;
    int n;
    d = (days_reg == 0) ? 1 : (days_reg > 8) ? 8 : int'(days_reg);
    s = (shifts_reg == 0) ? 1 : (shifts_reg > 4) ? 4 : int'(shifts_reg);
    n = d * s;
    if (n > MAX_ENTRIES_DEF) n = MAX_ENTRIES_DEF;
    return n;
  endfunction

  // Store one quantity; on a full set, sort stably and queue the balanced walk.
  task automatic stock_quantity(input logic [QTY_W-1:0] q);
    int    n;
    int    s;
    int    idx;
    int    cnt;
    int    i;
    int    j;
    int    sp;
    int    lo;
    int    hi;
    int    mid;
    int    pos;
    data_t ord [MAX_ENTRIES_DEF];
    data_t cur;
    int    lo_stk [2*MAX_ENTRIES_DEF];
    int    hi_stk [2*MAX_ENTRIES_DEF];
    emit_t r;
    n = cur_set_size();
    s = (shifts_reg == 0) ? 1 : (shifts_reg > 4) ? 4 : int'(shifts_reg);
    idx = (load_cnt >= n) ? 0 : load_cnt;
    stock[idx].qty   = q;
    stock[idx].day   = DAY_W'(idx / s + 1);
    stock[idx].shift = SHF_W'(idx % s + 1);
    load_cnt = idx + 1;
    if (load_cnt < n) return;
    cnt = load_cnt;
    for (i = 0; i < cnt; i++) ord[i] = stock[i];
    // packed order is qty, day, shift: compare as one key; strict > keeps it stable
    for (i = 1; i < cnt; i++) begin
      cur = ord[i];
      j = i - 1;
      while (j >= 0 && ord[j] > cur) begin
        ord[j + 1] = ord[j];
        j--;
      end
      ord[j + 1] = cur;
    end
    // preorder walk: midpoint, then left range, then right range
    sp = 0;
    lo_stk[0] = 0;
    hi_stk[0] = cnt - 1;
    sp = 1;
    pos = 0;
    while (sp > 0) begin
      sp--;
      lo = lo_stk[sp];
      hi = hi_stk[sp];
      if (lo <= hi) begin
        mid = (lo + hi) / 2;
        r.d = ord[mid];
        r.last = (pos == cnt - 1);
        fresh.push_back(r);
        pos++;
        lo_stk[sp] = mid + 1;
        hi_stk[sp] = hi;
        lo_stk[sp + 1] = lo;
        hi_stk[sp + 1] = mid - 1;
        sp += 2;
      end
    end
    load_cnt = 0;
    sets_done++;
  endtask

  function automatic stim_row_t mk_row(row_kind_t k, logic [CFG_W-1:0] dw,
                                       logic [CFG_W-1:0] sw, logic [QTY_W-1:0] q,
                                       logic typed);
    stim_row_t r;
    r.kind = k;
    r.days_w = dw;
    r.shifts_w = sw;
    r.qty = q;
    r.typed = typed;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_quantity(input logic [QTY_W-1:0] q, input logic typed);
    emit_t ex;
    if (!tail_quiet && gap_odds != 0 && $urandom_range(0, 7) < gap_odds * 2) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item_valid <= 1'b1;
    quantity   <= q;
    do @(posedge clk); while (item_stall);
    items_in++;
    stock_quantity(q);
    if (typed) begin
      ex.d.qty = q;
      ex.d.day = 1;
      ex.d.shift = 1;
      ex.last = 1'b1;
      due.push_back(ex);
    end else begin
      foreach (fresh[i]) due.push_back(fresh[i]);
    end
    fresh.delete();
    @(negedge clk);
  endtask

  // Wait for every owed result, then let any partial set settle in the cells.
  task automatic drain_and_pause();
    item_valid <= 1'b0;
    while (due.size() != 0) @(negedge clk);
    repeat (PAUSE) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] sw);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUM_DAYS;
    cfg_data  <= dw;
    @(posedge clk);
    days_reg = dw;
    @(negedge clk);
    cfg_index <= CFG_NUM_SHIFTS;
    cfg_data  <= sw;
    @(posedge clk);
    shifts_reg = sw[SHF_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_writes += 2;
  endtask

  // result side: random stall bursts between stretches of free flow
  initial begin
    forever begin
      result_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(60, 200)) @(negedge clk);
      else repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!tail_quiet && $urandom_range(0, 2) != 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      moved = (item_valid && !item_stall);
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_out++;
        if (due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: q=%0d d=%0d s=%0d last=%0b",
                     out_quantity, out_day, out_shift, is_last);
        end else begin
          head = due.pop_front();
          if (out_quantity !== head.d.qty || out_day !== head.d.day ||
              out_shift !== head.d.shift || is_last !== head.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: exp q=%0d d=%0d s=%0d last=%0b, ",
                        "got q=%0d d=%0d s=%0d last=%0b"},
                       head.d.qty, head.d.day, head.d.shift, head.last,
                       out_quantity, out_day, out_shift, is_last);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int cnt;
    int qmode;
    int rand_sent;
    int sel;
    logic [CFG_W-1:0] dw;
    logic [CFG_W-1:0] sw;
    logic [QTY_W-1:0] q;

    rst = 1'b1;
    item_valid = 1'b0;
    quantity = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_NUM_DAYS;
    cfg_data = '0;
    days_reg = DAYS_RST;
    shifts_reg = SHIFTS_RST;
    load_cnt = 0;
    mismatches = 0;
    items_in = 0;
    results_out = 0;
    sets_done = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    gap_odds = 1;
    tail_quiet = 1'b0;
    rand_sent = 0;
    qmode = 0;

    // single-entry sets: results can be typed in directly
    dir_rows.push_back(mk_row(ROW_CFG,  4'd1, 4'd1, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'h0000, 1'b1));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'hFFFF, 1'b1));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'hA5A5, 1'b1));
    // zero days and shifts saturate to one
    dir_rows.push_back(mk_row(ROW_CFG,  4'd0, 4'd0, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'h5A5A, 1'b1));
    // days above 8 saturate; repeated quantities fall back to day order
    dir_rows.push_back(mk_row(ROW_CFG,  4'd9, 4'd0, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd7, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd7, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'hFFFF, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd7, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd3, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'hFFFF, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd0, 1'b0));
    // set grows mid-load: day 2 shift 1 appears twice, load order must hold
    dir_rows.push_back(mk_row(ROW_CFG,  4'd4, 4'd1, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd5, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd5, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG,  4'd4, 4'b1010, '0, 1'b0));
    for (int i = 0; i < 6; i++) dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd5, 1'b0));
    // shifts above 4 saturate; then the set shrinks below the load count
    dir_rows.push_back(mk_row(ROW_CFG,  4'hF, 4'hF, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd1, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd2, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd3, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG,  4'd1, 4'd2, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd9, 1'b0));
    dir_rows.push_back(mk_row(ROW_ITEM, '0, '0, 16'd8, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_and_pause();
        write_cfg(dir_rows[i].days_w, dir_rows[i].shifts_w);
      end else begin
        offer_quantity(dir_rows[i].qty, dir_rows[i].typed);
      end
    end

    // random phases: new setting, then mostly whole sets, sometimes a partial one;
    // the quiet tail keeps the last setting and feeds without pauses
    while (rand_sent < RAND_ITEMS) begin
      if (!tail_quiet) begin
        drain_and_pause();
        sel = $urandom_range(0, 9);
        case (sel)
          0: begin dw = 4'd1; sw = 4'd1; end
          1: begin dw = 4'd8; sw = 4'd4; end
          2: begin dw = 4'hF; sw = 4'hF; end
          3: begin dw = 4'd0; sw = 4'd0; end
          4, 5: begin
            dw = CFG_W'($urandom_range(0, 15));
            sw = CFG_W'($urandom_range(0, 15));
          end
          default: begin
            dw = CFG_W'($urandom_range(1, 4));
            sw = CFG_W'($urandom_range(1, 3));
          end
        endcase
        write_cfg(dw, sw);
        gap_odds = $urandom_range(0, 2);
        qmode = $urandom_range(0, 3);
      end
      n = cur_set_size();
      if ($urandom_range(0, 3) != 0) cnt = n * ((n > 8) ? 1 : $urandom_range(1, 3));
      else cnt = $urandom_range(1, 2 * n);
      repeat (cnt) begin
        if (rand_sent >= RAND_ITEMS) break;
        if (rand_sent >= TAIL_START) tail_quiet = 1'b1;
        case (qmode)
          0: q = QTY_W'($urandom_range(0, 3));
          1: q = ($urandom_range(0, 2) == 0) ? 16'h0000 :
                 ($urandom_range(0, 1) == 0) ? 16'hFFFF : QTY_W'($urandom_range(0, 65535));
          default: q = QTY_W'($urandom_range(0, 65535));
        endcase
        offer_quantity(q, 1'b0);
        rand_sent++;
      end
    end

    item_valid <= 1'b0;
    while (due.size() != 0) @(negedge clk);
    repeat (PAUSE) @(negedge clk);

    $display("Loaded %0d quantities, %0d sets sorted, %0d results checked, %0d register writes.",
             items_in, sets_done, results_out, cfg_writes);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
